// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the box suppression checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted (active low)
`define GBN_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define GBN_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Types, constants and helpers of the greedy box suppression unit.
// ----------------------------------------------------------------------------
package gbn_pkg;

    // Store sizing
    localparam int MAX_BOXES = 64;
    localparam int IDX_W     = $clog2(MAX_BOXES);
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);

    // Field widths
    localparam int COORD_W  = 16;
    localparam int SIZE_W   = 15;
    localparam int SCORE_W  = 16;
    localparam int LIMIT_W  = 16;
    localparam int KIDX_W   = 6;
    localparam int SIDE_W   = 16;
    localparam int AREA_W   = 32;
    localparam int PROD_W   = 48;
    localparam int FRAC_W   = 16;

    // One pixel in Q12.4
    localparam int PIX_ONE = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd26214;

    // APB register map
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_OVERLAP_LIMIT = 1'b0;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic        [SIZE_W-1:0]  width;
        logic        [SIZE_W-1:0]  height;
    } t_box;

    localparam int BOX_W = $bits(t_box);

    // Response of the overlap unit
    typedef struct packed {
        logic done;
        logic hit;
    } t_iou_rsp;

    // Overlap length along one axis, +1 pixel convention, clamped at zero
    function automatic logic [SIDE_W-1:0] overlap_side(
        input logic signed [COORD_W-1:0] a_lo,
        input logic        [SIZE_W-1:0]  a_len,
        input logic signed [COORD_W-1:0] b_lo,
        input logic        [SIZE_W-1:0]  b_len
    );
        logic signed [COORD_W+1:0] alo;
        logic signed [COORD_W+1:0] blo;
        logic signed [COORD_W+1:0] ahi;
        logic signed [COORD_W+1:0] bhi;
        logic signed [COORD_W+1:0] lo;
        logic signed [COORD_W+1:0] hi;
        logic signed [COORD_W+1:0] d;
        alo = (COORD_W+2)'(a_lo);
        blo = (COORD_W+2)'(b_lo);
        ahi = alo + $signed({3'b000, a_len});
        bhi = blo + $signed({3'b000, b_len});
        lo  = (alo > blo) ? alo : blo;
        hi  = (ahi < bhi) ? ahi : bhi;
        d   = hi - lo + (COORD_W+2)'(PIX_ONE);
        if (d < 0) begin
            return '0;
        end
        return d[SIDE_W-1:0];
    endfunction

    // Side plus one pixel
    function automatic logic [SIDE_W-1:0] padded(input logic [SIZE_W-1:0] len);
        return {1'b0, len} + SIDE_W'(PIX_ONE);
    endfunction

endpackage

// ===== hdl/greedy_box_nms_unit.sv =====
// ----------------------------------------------------------------------------
// greedy_box_nms_unit
// Greedy non-maximum suppression of up to MAX_BOXES boxes by IoU threshold.
// ----------------------------------------------------------------------------
// Usage: boxes enter on the input channel (i_valid / o_stall), one per item,
// one item per cycle while loading. The item with i_final_box set closes the
// set; a box beyond MAX_BOXES is dropped. The block then holds o_stall high
// while it ranks the n stored boxes (one score RAM read port) and walks
// them in rank order; each pair test runs on the shared multiplier of the
// overlap unit, and there are at most n*(n-1)/2 of them. Kept load indices
// leave on the output channel (o_valid / i_stall) in score order, the last
// one flagged by o_last_kept. A kept box is reported once the next one is
// found, so the first result comes only after the ranking and the pair
// tests of the first kept box. A stalled output holds its item, and the
// walk waits at the next kept box until the item is taken.
// Reset (synchronous, active low) empties the set, clears the output and
// sets overlap_limit to 26214; suppression flags are cleared during ranking.
// ----------------------------------------------------------------------------
module greedy_box_nms_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // box input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [gbn_pkg::COORD_W-1:0] i_box_left,
    input  logic signed [gbn_pkg::COORD_W-1:0] i_box_top,
    input  logic [gbn_pkg::SIZE_W-1:0]         i_box_width,
    input  logic [gbn_pkg::SIZE_W-1:0]         i_box_height,
    input  logic [gbn_pkg::SCORE_W-1:0]        i_box_score,
    input  logic                               i_final_box,
    // kept box output channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [gbn_pkg::KIDX_W-1:0]         o_kept_index,
    output logic [gbn_pkg::SCORE_W-1:0]        o_kept_score,
    output logic                               o_last_kept,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gbn_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [gbn_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [gbn_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    typedef enum logic [4:0] {
        S_LOAD, S_SRI, S_SRD, S_SRJ, S_SCJ, S_SWR,
        S_PRA, S_PA, S_PCHK, S_PAD, S_PEMIT,
        S_QR, S_QB, S_QCHK, S_QBD, S_QGO, S_QWAIT, S_FLUSH
    } t_state;

    t_state                              r_state;
    logic [gbn_pkg::LIMIT_W-1:0]         r_limit;
    logic [gbn_pkg::CNT_W-1:0]           r_cnt;
    logic [gbn_pkg::CNT_W-1:0]           r_i;
    logic [gbn_pkg::CNT_W-1:0]           r_j;
    logic [gbn_pkg::CNT_W-1:0]           r_gt;
    logic [gbn_pkg::SCORE_W-1:0]         r_si;
    logic [gbn_pkg::IDX_W-1:0]           r_a;
    logic [gbn_pkg::IDX_W-1:0]           r_b;
    logic [gbn_pkg::SCORE_W-1:0]         r_sa;
    gbn_pkg::t_box                       r_boxa;
    gbn_pkg::t_box                       r_boxb;
    logic                                r_pend;
    logic [gbn_pkg::IDX_W-1:0]           r_pidx;
    logic [gbn_pkg::SCORE_W-1:0]         r_pscore;
    logic                                r_ov;
    logic [gbn_pkg::KIDX_W-1:0]          r_oidx;
    logic [gbn_pkg::SCORE_W-1:0]         r_oscore;
    logic                                r_olast;

    logic                                in_acc;
    logic                                not_full;
    logic                                slot_free;
    logic                                out_load;
    logic                                cfg_wr;
    logic                                iou_start;
    gbn_pkg::t_iou_rsp                   iou_rsp;
    logic                                ld_we;
    logic [gbn_pkg::IDX_W-1:0]           ld_addr;
    gbn_pkg::t_box                       ld_box;
    logic [gbn_pkg::IDX_W-1:0]           score_raddr;
    logic [gbn_pkg::IDX_W-1:0]           box_raddr;
    logic [gbn_pkg::IDX_W-1:0]           rank_raddr;
    logic [gbn_pkg::SCORE_W-1:0]         score_rdata;
    logic [gbn_pkg::BOX_W-1:0]           box_rdata;
    logic [gbn_pkg::IDX_W-1:0]           rank_rdata;
    logic                                score_gt;
    logic                                flag_we;
    logic [gbn_pkg::IDX_W-1:0]           flag_waddr;
    logic [0:0]                          flag_wdata;
    logic [0:0]                          flag_rdata;

    // Handshakes
    assign o_stall   = (r_state != S_LOAD);
    assign in_acc    = i_valid && !o_stall;
    assign not_full  = (r_cnt < gbn_pkg::CNT_W'(gbn_pkg::MAX_BOXES));
    assign slot_free = !r_ov || !i_stall;
    assign out_load  = slot_free && (((r_state == S_PEMIT) && r_pend) ||
                                     (r_state == S_FLUSH));
    assign iou_start = (r_state == S_QGO);

    // Load path into the stores
    assign ld_we          = in_acc && not_full;
    assign ld_addr        = r_cnt[gbn_pkg::IDX_W-1:0];
    assign ld_box.left    = i_box_left;
    assign ld_box.top     = i_box_top;
    assign ld_box.width   = i_box_width;
    assign ld_box.height  = i_box_height;

    // Read address selection
    always_comb begin
        unique case (r_state)
            S_SRI:   score_raddr = r_i[gbn_pkg::IDX_W-1:0];
            S_SRJ:   score_raddr = r_j[gbn_pkg::IDX_W-1:0];
            default: score_raddr = r_a;
        endcase
    end

    assign box_raddr  = (r_state == S_QCHK) ? r_b : r_a;
    assign rank_raddr = (r_state == S_QR) ? r_j[gbn_pkg::IDX_W-1:0]
                                          : r_i[gbn_pkg::IDX_W-1:0];

    // Suppression flags: cleared per box while ranking, set on a hit
    assign flag_we    = (r_state == S_SWR) ||
                        ((r_state == S_QWAIT) && iou_rsp.done && iou_rsp.hit);
    assign flag_waddr = (r_state == S_SWR) ? r_i[gbn_pkg::IDX_W-1:0] : r_b;
    assign flag_wdata = (r_state == S_QWAIT);

    // Rank order: higher score first, ties to lower load index
    assign score_gt = (score_rdata > r_si) || ((score_rdata == r_si) && (r_j < r_i));

    gbn_ram #(.WIDTH(gbn_pkg::BOX_W), .DEPTH(gbn_pkg::MAX_BOXES)) u_box_ram (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_waddr (ld_addr),
        .i_wdata (ld_box),
        .i_raddr (box_raddr),
        .o_rdata (box_rdata)
    );

    gbn_ram #(.WIDTH(gbn_pkg::SCORE_W), .DEPTH(gbn_pkg::MAX_BOXES)) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_waddr (ld_addr),
        .i_wdata (i_box_score),
        .i_raddr (score_raddr),
        .o_rdata (score_rdata)
    );

    gbn_ram #(.WIDTH(gbn_pkg::IDX_W), .DEPTH(gbn_pkg::MAX_BOXES)) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_SWR),
        .i_waddr (r_gt[gbn_pkg::IDX_W-1:0]),
        .i_wdata (r_i[gbn_pkg::IDX_W-1:0]),
        .i_raddr (rank_raddr),
        .o_rdata (rank_rdata)
    );

    // flag read follows the rank read, so it lands in the check state
    gbn_ram #(.WIDTH(1), .DEPTH(gbn_pkg::MAX_BOXES)) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (flag_we),
        .i_waddr (flag_waddr),
        .i_wdata (flag_wdata),
        .i_raddr (rank_rdata),
        .o_rdata (flag_rdata)
    );

    gbn_iou u_iou (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (iou_start),
        .i_box_a (r_boxa),
        .i_box_b (r_boxb),
        .i_limit (r_limit),
        .o_rsp   (iou_rsp)
    );

    // Configuration register
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[gbn_pkg::APB_ADDR_W-1] == gbn_pkg::REG_OVERLAP_LIMIT);
    assign pready = 1'b1;
    assign prdata = (paddr[gbn_pkg::APB_ADDR_W-1] == gbn_pkg::REG_OVERLAP_LIMIT)
                    ? gbn_pkg::APB_DATA_W'(r_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= gbn_pkg::LIMIT_RESET;
        end else if (cfg_wr) begin
            r_limit <= pwdata[gbn_pkg::LIMIT_W-1:0];
        end
    end

    // Sequencer: load, rank, suppress, flush
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            // output register drains on a taken item unless refilled
            if (r_ov && !i_stall && !out_load) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (not_full) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        if (i_final_box) begin
                            r_i     <= '0;
                            r_state <= S_SRI;
                        end
                    end
                end
                S_SRI: r_state <= S_SRD;
                S_SRD: begin
                    r_si    <= score_rdata;
                    r_j     <= '0;
                    r_gt    <= '0;
                    r_state <= S_SRJ;
                end
                S_SRJ: r_state <= S_SCJ;
                S_SCJ: begin
                    if (score_gt) begin
                        r_gt <= r_gt + 1'b1;
                    end
                    r_j     <= r_j + 1'b1;
                    r_state <= (r_j + 1'b1 == r_cnt) ? S_SWR : S_SRJ;
                end
                S_SWR: begin
                    if (r_i + 1'b1 == r_cnt) begin
                        r_i     <= '0;
                        r_state <= S_PRA;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SRI;
                    end
                end
                S_PRA: begin
                    r_state <= (r_i == r_cnt) ? S_FLUSH : S_PA;
                end
                S_PA: begin
                    r_a     <= rank_rdata;
                    r_state <= S_PCHK;
                end
                S_PCHK: begin
                    if (flag_rdata[0]) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_PRA;
                    end else begin
                        r_state <= S_PAD;
                    end
                end
                S_PAD: begin
                    r_boxa  <= box_rdata;
                    r_sa    <= score_rdata;
                    r_state <= S_PEMIT;
                end
                S_PEMIT: begin
                    // previous kept box is not the last one
                    if (slot_free) begin
                        if (r_pend) begin
                            r_ov     <= 1'b1;
                            r_oidx   <= gbn_pkg::KIDX_W'(r_pidx);
                            r_oscore <= r_pscore;
                            r_olast  <= 1'b0;
                        end
                        r_pend   <= 1'b1;
                        r_pidx   <= r_a;
                        r_pscore <= r_sa;
                        r_j      <= r_i + 1'b1;
                        r_state  <= S_QR;
                    end
                end
                S_QR: begin
                    if (r_j == r_cnt) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_PRA;
                    end else begin
                        r_state <= S_QB;
                    end
                end
                S_QB: begin
                    r_b     <= rank_rdata;
                    r_state <= S_QCHK;
                end
                S_QCHK: begin
                    if (flag_rdata[0]) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_QR;
                    end else begin
                        r_state <= S_QBD;
                    end
                end
                S_QBD: begin
                    r_boxb  <= box_rdata;
                    r_state <= S_QGO;
                end
                S_QGO: r_state <= S_QWAIT;
                S_QWAIT: begin
                    // flag RAM takes the hit on this edge
                    if (iou_rsp.done) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_QR;
                    end
                end
                S_FLUSH: begin
                    // pending box is the final kept one
                    if (slot_free) begin
                        r_ov     <= 1'b1;
                        r_oidx   <= gbn_pkg::KIDX_W'(r_pidx);
                        r_oscore <= r_pscore;
                        r_olast  <= 1'b1;
                        r_pend   <= 1'b0;
                        r_cnt    <= '0;
                        r_state  <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_valid      = r_ov;
    assign o_kept_index = r_oidx;
    assign o_kept_score = r_oscore;
    assign o_last_kept  = r_olast;

endmodule

// ===== hdl/gbn_ram.sv =====
// ----------------------------------------------------------------------------
// gbn_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gbn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/gbn_iou.sv =====
// ----------------------------------------------------------------------------
// gbn_iou
// Multi-cycle overlap test on one shared multiplier: inter*2^16 > limit*union.
// ----------------------------------------------------------------------------
module gbn_iou (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  gbn_pkg::t_box                  i_box_a,
    input  gbn_pkg::t_box                  i_box_b,
    input  logic [gbn_pkg::LIMIT_W-1:0]    i_limit,
    output gbn_pkg::t_iou_rsp              o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE, S_GEOM, S_MI, S_MA, S_MB, S_UN, S_ML, S_CMP
    } t_state;

    t_state                         r_state;
    logic [gbn_pkg::SIDE_W-1:0]     r_w;
    logic [gbn_pkg::SIDE_W-1:0]     r_h;
    logic [gbn_pkg::AREA_W-1:0]     r_inter;
    logic [gbn_pkg::AREA_W-1:0]     r_acc;
    logic [gbn_pkg::AREA_W-1:0]     r_uni;
    logic [gbn_pkg::PROD_W-1:0]     r_prod;
    logic                           r_done;
    logic                           r_hit;

    logic [gbn_pkg::AREA_W-1:0]     mul_a;
    logic [gbn_pkg::SIDE_W-1:0]     mul_b;
    logic [gbn_pkg::PROD_W-1:0]     mul_p;

    // Shared multiplier operand select
    always_comb begin
        unique case (r_state)
            S_MI: begin
                mul_a = gbn_pkg::AREA_W'(r_w);
                mul_b = r_h;
            end
            S_MA: begin
                mul_a = gbn_pkg::AREA_W'(gbn_pkg::padded(i_box_a.width));
                mul_b = gbn_pkg::padded(i_box_a.height);
            end
            S_MB: begin
                mul_a = gbn_pkg::AREA_W'(gbn_pkg::padded(i_box_b.width));
                mul_b = gbn_pkg::padded(i_box_b.height);
            end
            S_ML: begin
                mul_a = r_uni;
                mul_b = i_limit;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_GEOM;
                    end
                end
                S_GEOM: begin
                    r_w <= gbn_pkg::overlap_side(i_box_a.left, i_box_a.width,
                                                 i_box_b.left, i_box_b.width);
                    r_h <= gbn_pkg::overlap_side(i_box_a.top, i_box_a.height,
                                                 i_box_b.top, i_box_b.height);
                    r_state <= S_MI;
                end
                S_MI: r_state <= S_MA;
                S_MA: begin
                    r_inter <= r_prod[gbn_pkg::AREA_W-1:0];
                    r_state <= S_MB;
                end
                S_MB: begin
                    r_acc   <= r_prod[gbn_pkg::AREA_W-1:0];
                    r_state <= S_UN;
                end
                S_UN: begin
                    r_uni   <= r_acc + r_prod[gbn_pkg::AREA_W-1:0] - r_inter;
                    r_state <= S_ML;
                end
                S_ML: r_state <= S_CMP;
                S_CMP: begin
                    r_hit   <= {r_inter, {gbn_pkg::FRAC_W{1'b0}}} > r_prod;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.hit  = r_hit;

endmodule

// ===== hdl/gbn_checker.sv =====
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks of the suppression unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gbn_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        i_final_box,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [gbn_pkg::KIDX_W-1:0]  o_kept_index,
    input logic [gbn_pkg::SCORE_W-1:0] o_kept_score,
    input logic                        o_last_kept
);

    // A stalled result stays offered
    `GBN_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid, "result dropped while stalled")

    // A stalled result keeps its payload
    `GBN_ASSERT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall |=> $stable(o_kept_index) && $stable(o_kept_score) && $stable(o_last_kept), "result changed while stalled")

    // Closing the set starts the busy phase
    `GBN_ASSERT(a_busy_after_final, i_clk, i_rst_n, i_valid && !o_stall && i_final_box |=> o_stall, "input still open after final box")

    // Reset leaves an empty output and an open input
    `GBN_ASSERT_NR(a_reset_idle, i_clk, !i_rst_n |=> !o_valid && !o_stall, "unit not idle after reset")

endmodule

bind greedy_box_nms_unit gbn_checker u_gbn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_final_box  (i_final_box),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_kept_index (o_kept_index),
    .o_kept_score (o_kept_score),
    .o_last_kept  (o_last_kept)
);
